// ===== design/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Default sizes, page kind codes and result status codes shared by the
// allocator core and its size decoder.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int DEF_MAX_ORDER      = 6;
   localparam int DEF_TOTAL_PAGES    = 256;
   localparam int DEF_PAGE_SIZE_LOG2 = 12;

   localparam logic [1:0] KIND_FREE_HEAD  = 2'd0;
   localparam logic [1:0] KIND_FREE_TAIL  = 2'd1;
   localparam logic [1:0] KIND_ALLOC_HEAD = 2'd2;
   localparam logic [1:0] KIND_ALLOC_TAIL = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

endpackage

// ===== design/bpa_size_decode.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator size decoder
// Rounds a byte count up to the smallest block order that holds it and flags
// requests larger than the largest block.
// ----------------------------------------------------------------------------
module bpa_size_decode #(
   parameter int MAX_ORDER_VALUE = bpa_pkg::DEF_MAX_ORDER,
   parameter int PAGE_SIZE_LOG2  = bpa_pkg::DEF_PAGE_SIZE_LOG2
) (
   input  logic [31:0]                              request_bytes,
   output logic                                     fits,
   output logic [$clog2(MAX_ORDER_VALUE + 1) - 1:0] order
);
   import bpa_pkg::*;

   localparam int OW = $clog2(MAX_ORDER_VALUE + 1);

   always_comb begin
      fits  = 1'b0;
      order = '0;
      for (int o = MAX_ORDER_VALUE; o >= 0; o--) begin
         if ({1'b0, request_bytes} <= (33'(1) << (PAGE_SIZE_LOG2 + o))) begin
            fits  = 1'b1;
            order = OW'(o);
         end
      end
   end

endmodule

// ===== design/buddy_page_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator core
// Allocates and frees power-of-two page blocks from a fixed pool, keeping one
// tail-appended free list per order.
// ----------------------------------------------------------------------------
// After reset the core sweeps the page and link memories, writing every
// page, and accepts no request until that is done. Each request is then
// handled on its own by a sequencer around a page memory and a link memory,
// both with registered synchronous reads. An allocation splits larger blocks
// down to the requested order (ST_SP0 to ST_SP4 per split), takes the block
// (ST_TK0, ST_TK1) and marks its pages one by one; a free checks the block
// (ST_FR0, ST_FR1), releases its pages, merges while the buddy is a free head
// of the same order below the top order, and appends the block (ST_FIN0,
// ST_FIN1). ST_RESP loads the result beat when the response channel allows.
module buddy_page_allocator_core #(
   parameter int MAX_ORDER_VALUE = bpa_pkg::DEF_MAX_ORDER,
   parameter int TOTAL_PAGES     = bpa_pkg::DEF_TOTAL_PAGES,
   parameter int PAGE_SIZE_LOG2  = bpa_pkg::DEF_PAGE_SIZE_LOG2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [31:0] req_request_bytes,
   input  logic [7:0]  req_page_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_start_page,
   output logic [2:0]  rsp_block_order
);
   import bpa_pkg::*;

   localparam int PW    = $clog2(TOTAL_PAGES);
   localparam int LW    = PW + 1;
   localparam int OW    = $clog2(MAX_ORDER_VALUE + 1);
   localparam int CW    = MAX_ORDER_VALUE + 1;
   localparam int BSIZE = 1 << MAX_ORDER_VALUE;
   localparam int NBLK  = TOTAL_PAGES / BSIZE;
   localparam logic [LW-1:0] NIL = LW'(TOTAL_PAGES);

   localparam logic [4:0] ST_INIT   = 5'd0;
   localparam logic [4:0] ST_IDLE   = 5'd1;
   localparam logic [4:0] ST_SP0    = 5'd2;
   localparam logic [4:0] ST_SP1    = 5'd3;
   localparam logic [4:0] ST_SP2    = 5'd4;
   localparam logic [4:0] ST_SP3    = 5'd5;
   localparam logic [4:0] ST_SP4    = 5'd6;
   localparam logic [4:0] ST_TK0    = 5'd7;
   localparam logic [4:0] ST_TK1    = 5'd8;
   localparam logic [4:0] ST_MARK_A = 5'd9;
   localparam logic [4:0] ST_FR0    = 5'd10;
   localparam logic [4:0] ST_FR1    = 5'd11;
   localparam logic [4:0] ST_MARK_F = 5'd12;
   localparam logic [4:0] ST_MG0    = 5'd13;
   localparam logic [4:0] ST_MG1    = 5'd14;
   localparam logic [4:0] ST_MG2    = 5'd15;
   localparam logic [4:0] ST_MG3    = 5'd16;
   localparam logic [4:0] ST_FIN0   = 5'd17;
   localparam logic [4:0] ST_FIN1   = 5'd18;
   localparam logic [4:0] ST_RESP   = 5'd19;

   typedef struct packed {
      logic [1:0]    kind;
      logic [OW-1:0] order;
      logic [PW-1:0] start;
   } page_type;

   typedef struct packed {
      logic [LW-1:0] next;
      logic [LW-1:0] prev;
   } link_type;

   page_type page_mem [TOTAL_PAGES];
   link_type link_mem [TOTAL_PAGES];

   page_type      pg_rd_ff, pg_wdata;
   link_type      lk_rd_ff, lk_wdata;
   logic [PW-1:0] pg_raddr, pg_waddr, lk_raddr, lk_waddr;
   logic          pg_re, lk_re;
   logic          pg_we_kind, pg_we_order, pg_we_start, lk_we_next, lk_we_prev;

   logic [4:0]    state_ff, state_in;
   logic [PW-1:0] init_ff, init_in;
   logic [OW-1:0] ord_ff, ord_in, req_ord_ff, req_ord_in;
   logic [PW-1:0] blk_ff, blk_in, tmp_ff, tmp_in;
   logic [LW-1:0] tail_ff, tail_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [LW-1:0] first_ff [MAX_ORDER_VALUE + 1];
   logic [LW-1:0] first_in [MAX_ORDER_VALUE + 1];
   logic [LW-1:0] last_ff  [MAX_ORDER_VALUE + 1];
   logic [LW-1:0] last_in  [MAX_ORDER_VALUE + 1];
   logic [1:0]    res_status_ff, res_status_in;
   logic [PW-1:0] res_page_ff, res_page_in;
   logic [OW-1:0] res_ord_ff, res_ord_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [7:0]    rsp_start_page_ff, rsp_start_page_in;
   logic [2:0]    rsp_block_order_ff, rsp_block_order_in;

   logic          size_fits, avail_found;
   logic [OW-1:0] size_order, avail_order, ord_m1;
   logic [PW-1:0] hi_page, buddy_page;
   logic [CW-1:0] mark_last;
   logic [PW:0]   free_page;

   bpa_size_decode #(
      .MAX_ORDER_VALUE (MAX_ORDER_VALUE),
      .PAGE_SIZE_LOG2  (PAGE_SIZE_LOG2)
   ) u_size_decode (
      .request_bytes (req_request_bytes),
      .fits          (size_fits),
      .order         (size_order)
   );

   always_comb begin
      avail_found = 1'b0;
      avail_order = '0;
      for (int o = MAX_ORDER_VALUE; o >= 0; o--) begin
         if (OW'(o) >= size_order && first_ff[o] != NIL) begin
            avail_found = 1'b1;
            avail_order = OW'(o);
         end
      end
   end

   assign ord_m1     = ord_ff - OW'(1);
   assign hi_page    = blk_ff + (PW'(1) << ord_m1);
   assign buddy_page = blk_ff ^ (PW'(1) << ord_ff);
   assign mark_last  = (CW'(1) << ord_ff) - CW'(1);
   assign free_page  = {1'b0, blk_ff} + (PW + 1)'(cnt_ff);

   always_comb begin
      state_in      = state_ff;
      init_in       = init_ff;
      ord_in        = ord_ff;
      req_ord_in    = req_ord_ff;
      blk_in        = blk_ff;
      tmp_in        = tmp_ff;
      tail_in       = tail_ff;
      cnt_in        = cnt_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      res_status_in = res_status_ff;
      res_page_in   = res_page_ff;
      res_ord_in    = res_ord_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_status_in      = rsp_status_ff;
      rsp_start_page_in  = rsp_start_page_ff;
      rsp_block_order_in = rsp_block_order_ff;
      pg_raddr    = blk_ff;
      lk_raddr    = blk_ff;
      pg_re       = 1'b0;
      lk_re       = 1'b0;
      pg_waddr    = blk_ff;
      lk_waddr    = blk_ff;
      pg_wdata    = '0;
      lk_wdata    = '0;
      pg_we_kind  = 1'b0;
      pg_we_order = 1'b0;
      pg_we_start = 1'b0;
      lk_we_next  = 1'b0;
      lk_we_prev  = 1'b0;

      unique case (state_ff)
         ST_INIT: begin
            pg_waddr    = init_ff;
            lk_waddr    = init_ff;
            pg_we_kind  = 1'b1;
            pg_we_order = 1'b1;
            pg_we_start = 1'b1;
            lk_we_next  = 1'b1;
            lk_we_prev  = 1'b1;
            pg_wdata.order = OW'(MAX_ORDER_VALUE);
            lk_wdata.next  = NIL;
            lk_wdata.prev  = NIL;
            if ((int'(init_ff) % BSIZE) == 0 && int'(init_ff) + BSIZE <= TOTAL_PAGES) begin
               pg_wdata.kind = KIND_FREE_HEAD;
               if (int'(init_ff) + 2 * BSIZE <= TOTAL_PAGES) begin
                  lk_wdata.next = LW'(int'(init_ff) + BSIZE);
               end
               if (int'(init_ff) >= BSIZE) begin
                  lk_wdata.prev = LW'(int'(init_ff) - BSIZE);
               end
            end else begin
               pg_wdata.kind = KIND_FREE_TAIL;
            end
            init_in = init_ff + PW'(1);
            if (init_ff == PW'(TOTAL_PAGES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (!req_action) begin
                  if (!size_fits || !avail_found) begin
                     res_status_in = STATUS_NO_SPACE;
                     res_page_in   = '0;
                     res_ord_in    = '0;
                     state_in      = ST_RESP;
                  end else begin
                     req_ord_in = size_order;
                     ord_in     = avail_order;
                     state_in   = (avail_order > size_order) ? ST_SP0 : ST_TK0;
                  end
               end else if (int'(req_page_index) >= TOTAL_PAGES) begin
                  res_status_in = STATUS_BAD_FREE;
                  res_page_in   = '0;
                  res_ord_in    = '0;
                  state_in      = ST_RESP;
               end else begin
                  blk_in   = PW'(req_page_index);
                  state_in = ST_FR0;
               end
            end
         end
         ST_SP0: begin
            blk_in   = first_ff[ord_ff][PW-1:0];
            lk_raddr = first_ff[ord_ff][PW-1:0];
            lk_re    = 1'b1;
            state_in = ST_SP1;
         end
         ST_SP1: begin
            first_in[ord_ff] = lk_rd_ff.next;
            if (lk_rd_ff.next == NIL) begin
               last_in[ord_ff] = NIL;
            end else begin
               lk_waddr      = lk_rd_ff.next[PW-1:0];
               lk_wdata.prev = NIL;
               lk_we_prev    = 1'b1;
            end
            pg_wdata.kind  = KIND_FREE_HEAD;
            pg_wdata.order = ord_m1;
            pg_we_kind     = 1'b1;
            pg_we_order    = 1'b1;
            state_in       = ST_SP2;
         end
         ST_SP2: begin
            tail_in        = last_ff[ord_m1];
            lk_wdata.next  = {1'b0, hi_page};
            lk_wdata.prev  = last_ff[ord_m1];
            lk_we_next     = 1'b1;
            lk_we_prev     = 1'b1;
            pg_waddr       = hi_page;
            pg_wdata.kind  = KIND_FREE_HEAD;
            pg_wdata.order = ord_m1;
            pg_we_kind     = 1'b1;
            pg_we_order    = 1'b1;
            state_in       = ST_SP3;
         end
         ST_SP3: begin
            lk_waddr      = hi_page;
            lk_wdata.next = NIL;
            lk_wdata.prev = {1'b0, blk_ff};
            lk_we_next    = 1'b1;
            lk_we_prev    = 1'b1;
            state_in      = ST_SP4;
         end
         ST_SP4: begin
            if (tail_ff == NIL) begin
               first_in[ord_m1] = {1'b0, blk_ff};
            end else begin
               lk_waddr      = tail_ff[PW-1:0];
               lk_wdata.next = {1'b0, blk_ff};
               lk_we_next    = 1'b1;
            end
            last_in[ord_m1] = {1'b0, hi_page};
            ord_in          = ord_m1;
            state_in        = (ord_m1 > req_ord_ff) ? ST_SP0 : ST_TK0;
         end
         ST_TK0: begin
            blk_in   = first_ff[req_ord_ff][PW-1:0];
            lk_raddr = first_ff[req_ord_ff][PW-1:0];
            lk_re    = 1'b1;
            ord_in   = req_ord_ff;
            state_in = ST_TK1;
         end
         ST_TK1: begin
            first_in[ord_ff] = lk_rd_ff.next;
            if (lk_rd_ff.next == NIL) begin
               last_in[ord_ff] = NIL;
            end else begin
               lk_waddr      = lk_rd_ff.next[PW-1:0];
               lk_wdata.prev = NIL;
               lk_we_prev    = 1'b1;
            end
            cnt_in   = '0;
            state_in = ST_MARK_A;
         end
         ST_MARK_A: begin
            pg_waddr       = free_page[PW-1:0];
            pg_wdata.kind  = (cnt_ff == '0) ? KIND_ALLOC_HEAD : KIND_ALLOC_TAIL;
            pg_wdata.order = ord_ff;
            pg_wdata.start = blk_ff;
            pg_we_kind     = 1'b1;
            pg_we_order    = 1'b1;
            pg_we_start    = 1'b1;
            cnt_in         = cnt_ff + CW'(1);
            if (cnt_ff == mark_last) begin
               res_status_in = STATUS_OK;
               res_page_in   = blk_ff;
               res_ord_in    = ord_ff;
               state_in      = ST_RESP;
            end
         end
         ST_FR0: begin
            pg_re    = 1'b1;
            state_in = ST_FR1;
         end
         ST_FR1: begin
            if (pg_rd_ff.kind != KIND_ALLOC_HEAD || pg_rd_ff.start != blk_ff) begin
               res_status_in = STATUS_BAD_FREE;
               res_page_in   = '0;
               res_ord_in    = '0;
               state_in      = ST_RESP;
            end else begin
               ord_in   = (int'(pg_rd_ff.order) > MAX_ORDER_VALUE) ?
                          OW'(MAX_ORDER_VALUE) : pg_rd_ff.order;
               cnt_in   = '0;
               state_in = ST_MARK_F;
            end
         end
         ST_MARK_F: begin
            pg_waddr       = free_page[PW-1:0];
            pg_wdata.kind  = KIND_FREE_TAIL;
            pg_wdata.order = ord_ff;
            pg_we_kind     = int'(free_page) < TOTAL_PAGES;
            pg_we_order    = int'(free_page) < TOTAL_PAGES;
            cnt_in         = cnt_ff + CW'(1);
            if (cnt_ff == mark_last) begin
               state_in = ST_MG0;
            end
         end
         ST_MG0: begin
            if (int'(ord_ff) >= MAX_ORDER_VALUE || int'(buddy_page) >= TOTAL_PAGES) begin
               state_in = ST_FIN0;
            end else begin
               tmp_in   = buddy_page;
               pg_raddr = buddy_page;
               pg_re    = 1'b1;
               state_in = ST_MG1;
            end
         end
         ST_MG1: begin
            if (pg_rd_ff.kind != KIND_FREE_HEAD || pg_rd_ff.order != ord_ff) begin
               state_in = ST_FIN0;
            end else begin
               pg_waddr      = tmp_ff;
               pg_wdata.kind = KIND_FREE_TAIL;
               pg_we_kind    = 1'b1;
               lk_raddr      = tmp_ff;
               lk_re         = 1'b1;
               state_in      = ST_MG2;
            end
         end
         ST_MG2: begin
            if (lk_rd_ff.prev == NIL) begin
               first_in[ord_ff] = lk_rd_ff.next;
            end else begin
               lk_waddr      = lk_rd_ff.prev[PW-1:0];
               lk_wdata.next = lk_rd_ff.next;
               lk_we_next    = 1'b1;
            end
            state_in = ST_MG3;
         end
         ST_MG3: begin
            if (lk_rd_ff.next == NIL) begin
               last_in[ord_ff] = lk_rd_ff.prev;
            end else begin
               lk_waddr      = lk_rd_ff.next[PW-1:0];
               lk_wdata.prev = lk_rd_ff.prev;
               lk_we_prev    = 1'b1;
            end
            blk_in   = (tmp_ff < blk_ff) ? tmp_ff : blk_ff;
            ord_in   = ord_ff + OW'(1);
            state_in = ST_MG0;
         end
         ST_FIN0: begin
            pg_wdata.kind  = KIND_FREE_HEAD;
            pg_wdata.order = ord_ff;
            pg_we_kind     = 1'b1;
            pg_we_order    = 1'b1;
            tail_in        = last_ff[ord_ff];
            lk_wdata.next  = NIL;
            lk_wdata.prev  = last_ff[ord_ff];
            lk_we_next     = 1'b1;
            lk_we_prev     = 1'b1;
            state_in       = ST_FIN1;
         end
         ST_FIN1: begin
            if (tail_ff == NIL) begin
               first_in[ord_ff] = {1'b0, blk_ff};
            end else begin
               lk_waddr      = tail_ff[PW-1:0];
               lk_wdata.next = {1'b0, blk_ff};
               lk_we_next    = 1'b1;
            end
            last_in[ord_ff] = {1'b0, blk_ff};
            res_status_in   = STATUS_OK;
            res_page_in     = blk_ff;
            res_ord_in      = ord_ff;
            state_in        = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_status_in      = res_status_ff;
               rsp_start_page_in  = 8'(res_page_ff);
               rsp_block_order_in = 3'(res_ord_ff);
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (pg_we_kind) begin
         page_mem[pg_waddr].kind <= pg_wdata.kind;
      end
      if (pg_we_order) begin
         page_mem[pg_waddr].order <= pg_wdata.order;
      end
      if (pg_we_start) begin
         page_mem[pg_waddr].start <= pg_wdata.start;
      end
      if (pg_re) begin
         pg_rd_ff <= page_mem[pg_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (lk_we_next) begin
         link_mem[lk_waddr].next <= lk_wdata.next;
      end
      if (lk_we_prev) begin
         link_mem[lk_waddr].prev <= lk_wdata.prev;
      end
      if (lk_re) begin
         lk_rd_ff <= link_mem[lk_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int o = 0; o <= MAX_ORDER_VALUE; o++) begin
            first_ff[o] <= (o == MAX_ORDER_VALUE && NBLK > 0) ? LW'(0) : NIL;
            last_ff[o]  <= (o == MAX_ORDER_VALUE && NBLK > 0) ?
                           LW'((NBLK - 1) * BSIZE) : NIL;
         end
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
      end
      ord_ff             <= ord_in;
      req_ord_ff         <= req_ord_in;
      blk_ff             <= blk_in;
      tmp_ff             <= tmp_in;
      tail_ff            <= tail_in;
      cnt_ff             <= cnt_in;
      res_status_ff      <= res_status_in;
      res_page_ff        <= res_page_in;
      res_ord_ff         <= res_ord_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_start_page_ff  <= rsp_start_page_in;
      rsp_block_order_ff <= rsp_block_order_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_start_page  = rsp_start_page_ff;
   assign rsp_block_order = rsp_block_order_ff;

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("Accepted request beat did not start the sequencer.");

   a_error_beat_zeroed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STATUS_OK) |->
      (rsp_start_page_ff == '0 && rsp_block_order_ff == '0))
      else $error("Error result beat carries a nonzero page or order.");

   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT) |-> req_stall)
      else $error("Request beat accepted during the initialization sweep.");

   a_resp_loads_beat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && (!rsp_valid_ff || !rsp_stall)) |=>
      (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("Finished request did not produce a result beat.");
`endif

endmodule

// ===== tb/buddy_page_allocator_core_checker.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator checker
// Watches the request and response channels of the allocator core, keeps its
// own copy of the page pool and free lists, predicts each response beat and
// compares it field by field with what the core returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module buddy_page_allocator_core_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_action,
   input  logic [31:0] req_request_bytes,
   input  logic [7:0]  req_page_index,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic [7:0]  rsp_start_page,
   input  logic [2:0]  rsp_block_order,
   output int          fail_count,
   output int          pending_count
);
   import bpa_pkg::*;

   localparam int MAXO  = DEF_MAX_ORDER;
   localparam int PAGES = DEF_TOTAL_PAGES;
   localparam int PLOG  = DEF_PAGE_SIZE_LOG2;
   localparam logic [8:0] NULL_LINK = 9'(PAGES);

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] start_page;
      logic [2:0] block_order;
   } alloc_result_type;

   logic [1:0] kind     [PAGES];
   logic [2:0] blk_ord  [PAGES];
   logic [7:0] blk_base [PAGES];
   logic [8:0] nxt      [PAGES];
   logic [8:0] prv      [PAGES];
   logic [8:0] head     [MAXO+1];
   logic [8:0] tail     [MAXO+1];
   alloc_result_type expected_results[$];

   assign pending_count = expected_results.size();

   function automatic void push_tail(int o, logic [8:0] p);
      prv[p] = tail[o];
      nxt[p] = NULL_LINK;
      if (tail[o] == NULL_LINK) head[o] = p;
      else nxt[tail[o]] = p;
      tail[o] = p;
   endfunction

   function automatic void remove_entry(int o, logic [8:0] p);
      logic [8:0] a;
      logic [8:0] b;
      a = prv[p];
      b = nxt[p];
      if (a == NULL_LINK) head[o] = b;
      else nxt[a] = b;
      if (b == NULL_LINK) tail[o] = a;
      else prv[b] = a;
      nxt[p] = NULL_LINK;
      prv[p] = NULL_LINK;
   endfunction

   function automatic void clear_pool();
      for (int o = 0; o <= MAXO; o++) begin
         head[o] = NULL_LINK;
         tail[o] = NULL_LINK;
      end
      for (int p = 0; p < PAGES; p++) begin
         blk_ord[p] = 3'(MAXO);
         blk_base[p] = '0;
         nxt[p] = NULL_LINK;
         prv[p] = NULL_LINK;
         if (p % (1 << MAXO) == 0 && p + (1 << MAXO) <= PAGES) begin
            kind[p] = KIND_FREE_HEAD;
            push_tail(MAXO, 9'(p));
         end else begin
            kind[p] = KIND_FREE_TAIL;
         end
      end
   endfunction

   function automatic alloc_result_type allocate_block(logic [31:0] bytes);
      int want;
      int a;
      logic [8:0] r;
      logic [8:0] hi;
      alloc_result_type res;
      res = '{STATUS_NO_SPACE, 8'd0, 3'd0};
      want = -1;
      for (int o = MAXO; o >= 0; o--)
         if (64'(bytes) <= (64'd1 << (PLOG + o))) want = o;
      if (want < 0) return res;
      a = want;
      while (a <= MAXO && head[a] == NULL_LINK) a++;
      if (a > MAXO) return res;
      while (a > want) begin
         r = head[a];
         hi = r + 9'(1 << (a - 1));
         remove_entry(a, r);
         push_tail(a - 1, r);
         push_tail(a - 1, hi);
         blk_ord[r] = 3'(a - 1);
         blk_ord[hi] = 3'(a - 1);
         kind[r] = KIND_FREE_HEAD;
         kind[hi] = KIND_FREE_HEAD;
         a--;
      end
      r = head[want];
      remove_entry(want, r);
      for (int i = 0; i < (1 << want); i++) begin
         kind[r + i] = (i == 0) ? KIND_ALLOC_HEAD : KIND_ALLOC_TAIL;
         blk_ord[r + i] = 3'(want);
         blk_base[r + i] = r[7:0];
      end
      return '{STATUS_OK, r[7:0], 3'(want)};
   endfunction

   function automatic alloc_result_type release_block(logic [7:0] page);
      int o;
      int idx;
      int bud;
      idx = page;
      if (kind[idx] != KIND_ALLOC_HEAD || blk_base[idx] != page)
         return '{STATUS_BAD_FREE, 8'd0, 3'd0};
      o = blk_ord[idx];
      for (int i = 0; i < (1 << o); i++)
         if (idx + i < PAGES) begin
            kind[idx + i] = KIND_FREE_TAIL;
            blk_ord[idx + i] = 3'(o);
         end
      while (o < MAXO) begin
         bud = idx ^ (1 << o);
         if (bud >= PAGES || kind[bud] != KIND_FREE_HEAD || blk_ord[bud] != 3'(o)) break;
         remove_entry(o, 9'(bud));
         kind[bud] = KIND_FREE_TAIL;
         if (bud < idx) idx = bud;
         o++;
      end
      kind[idx] = KIND_FREE_HEAD;
      blk_ord[idx] = 3'(o);
      push_tail(o, 9'(idx));
      return '{STATUS_OK, 8'(idx), 3'(o)};
   endfunction

   always @(posedge clock) begin
      alloc_result_type got;
      alloc_result_type want;
      if (reset) begin
         clear_pool();
         expected_results.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_action) expected_results.push_back(release_block(req_page_index));
            else expected_results.push_back(allocate_block(req_request_bytes));
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_start_page, rsp_block_order};
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual %p", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== tb/buddy_page_allocator_core_tb.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator testbench
// Drives directed and random allocate and free requests into the allocator
// core with random idling on both channels; a checker beside the core predicts
// and compares every response beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module buddy_page_allocator_core_tb;
   import bpa_pkg::*;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;
   localparam int   WATCHDOG_LIMIT = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = 1'b0;
   logic [31:0] req_request_bytes = '0;
   logic [7:0]  req_page_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_start_page;
   logic [2:0]  rsp_block_order;
   int          fail_count;
   int          pending_count;
   int          idle_cycles = 0;
   bit          calm = 1'b0;
   logic [7:0]  held_pages[$];

   always #5 clock = ~clock;

   buddy_page_allocator_core dut (.*);

   buddy_page_allocator_core_checker u_checker (.*);

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Receiver stalls in random bursts while the bench is not calm.
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 11);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_beat(logic act, logic [31:0] bytes, logic [7:0] page);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_request_bytes <= bytes;
      req_page_index <= page;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic alloc_size(int o);
      logic [31:0] lo;
      logic [31:0] hi;
      hi = 32'd1 << (DEF_PAGE_SIZE_LOG2 + o);
      lo = (o == 0) ? 32'd0 : (hi >> 1) + 1;
      send_beat(ACT_ALLOC, $urandom_range(lo, hi), 8'($urandom));
   endtask

   task automatic send_free(logic [7:0] page);
      send_beat(ACT_FREE, $urandom, page);
   endtask

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall && rsp_status == STATUS_OK)
         held_pages.push_back(rsp_start_page);

   initial begin
      int k;
      int wait_cycles;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_beat(ACT_ALLOC, 32'd0, 8'hff);
      send_beat(ACT_ALLOC, 32'd4096, 8'h00);
      send_beat(ACT_ALLOC, 32'd4097, 8'h00);
      send_beat(ACT_ALLOC, 32'd262144, 8'h00);
      send_beat(ACT_ALLOC, 32'd262145, 8'h00);
      send_beat(ACT_ALLOC, 32'hffffffff, 8'h00);
      send_beat(ACT_FREE, 32'hffffffff, 8'd0);
      send_beat(ACT_FREE, 32'd0, 8'd1);
      send_beat(ACT_FREE, 32'd0, 8'd255);
      send_beat(ACT_FREE, 32'd0, 8'd0);
      send_beat(ACT_FREE, 32'd0, 8'd0);
      for (int i = 0; i < 6; i++) send_beat(ACT_ALLOC, 32'd262144, 8'h00);
      for (int i = 0; i < 4; i++) send_free(8'(i * 64));

      // Random part: the pool is kept moving, with frees mostly of live blocks.
      for (int i = 0; i < 1650; i++) begin
         if (i > 1450) calm = 1'b1;
         k = $urandom_range(0, 99);
         if (k < 45) alloc_size($urandom_range(0, 99) < 80 ? $urandom_range(0, 3)
                                                            : $urandom_range(0, 6));
         else if (k < 90 && held_pages.size() > 0)
            send_free(held_pages[$urandom_range(0, held_pages.size() - 1)]);
         else if (k < 95) send_free(8'($urandom));
         else send_beat(ACT_ALLOC, $urandom, 8'($urandom));
         if (held_pages.size() > 200) void'(held_pages.pop_front());
      end
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
